/* hdl/api_frame_deframer_assert.svh */
// Assertion macros shared by the frame deframer RTL.
`ifndef API_FRAME_DEFRAMER_ASSERT_SVH
`define API_FRAME_DEFRAMER_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication.
`define AFD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define AFD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define AFD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define AFD_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* hdl/afd_pkg.sv */
// Types and constants of the frame deframer.
package afd_pkg;

	localparam logic [7:0] PREAMBLE = 8'hED;

	localparam int REG_ADDR_W = 1;
	localparam int REG_DATA_W = 16;

	localparam logic [REG_ADDR_W-1:0] REG_LENGTH_MSB_FIRST = 1'd0;
	localparam logic [REG_ADDR_W-1:0] REG_MAX_PAYLOAD_LEN  = 1'd1;

	localparam logic        RST_LENGTH_MSB_FIRST = 1'b1;
	localparam logic [15:0] RST_MAX_PAYLOAD_LEN  = 16'd255;

	localparam logic [1:0] ST_GOOD     = 2'd0;
	localparam logic [1:0] ST_BAD_SUM  = 2'd1;
	localparam logic [1:0] ST_TOO_LONG = 2'd2;

	typedef struct packed {
		logic        length_msb_first;
		logic [15:0] max_payload_len;
	} afd_cfg_t;

	typedef struct packed {
		logic [7:0]  payload_byte;
		logic [7:0]  frame_kind;
		logic [15:0] byte_index;
		logic        frame_end;
		logic [1:0]  status;
	} afd_result_t;

endpackage

/* hdl/afd_if.sv */
// Channel interfaces of the frame deframer: byte stream, results, register writes.
interface afd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink   (input valid, input in_byte, output ready);
endinterface

interface afd_result_if;
	logic        valid;
	logic        ready;
	logic [7:0]  payload_byte;
	logic [7:0]  frame_kind;
	logic [15:0] byte_index;
	logic        frame_end;
	logic [1:0]  status;

	modport source (output valid, output payload_byte, output frame_kind,
		output byte_index, output frame_end, output status, input ready);
	modport sink   (input valid, input payload_byte, input frame_kind,
		input byte_index, input frame_end, input status, output ready);
endinterface

interface afd_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [afd_pkg::REG_ADDR_W-1:0] addr;
	logic [afd_pkg::REG_DATA_W-1:0] data;

	modport source (output valid, output addr, output data, input ready);
	modport sink   (input valid, input addr, input data, output ready);
endinterface

/* hdl/afd_parser.sv */
// Frame parser: header, payload and checksum state, one byte per step.
`include "api_frame_deframer_assert.svh"

module afd_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            in_byte,
	input  afd_pkg::afd_cfg_t     cfg,
	output logic                  has_result,
	output afd_pkg::afd_result_t  res
);

	localparam logic [2:0] PH_HUNT  = 3'd0;
	localparam logic [2:0] PH_TYPE  = 3'd1;
	localparam logic [2:0] PH_LEN1  = 3'd2;
	localparam logic [2:0] PH_LEN2  = 3'd3;
	localparam logic [2:0] PH_DATA  = 3'd4;
	localparam logic [2:0] PH_CHECK = 3'd5;

	logic [2:0]  phase_q, phase_d;
	logic [7:0]  kind_q, kind_d;
	logic [15:0] len_q, len_d;
	logic [15:0] count_q, count_d;
	logic [7:0]  sum_q, sum_d;
	logic [15:0] new_len;
	logic [15:0] count_inc;
	logic [7:0]  sum_add;

	assign new_len   = cfg.length_msb_first ? {len_q[7:0], in_byte} : {in_byte, len_q[7:0]};
	assign count_inc = count_q + 16'd1;
	assign sum_add   = sum_q + in_byte;

	always_comb begin
		phase_d = phase_q;
		kind_d  = kind_q;
		len_d   = len_q;
		count_d = count_q;
		sum_d   = sum_q;
		has_result       = 1'b0;
		res.payload_byte = '0;
		res.frame_kind   = kind_q;
		res.byte_index   = '0;
		res.frame_end    = 1'b0;
		res.status       = afd_pkg::ST_GOOD;
		unique case (phase_q)
			PH_TYPE: begin
				kind_d  = in_byte;
				sum_d   = sum_add;
				phase_d = PH_LEN1;
			end
			PH_LEN1: begin
				len_d   = {8'd0, in_byte};
				sum_d   = sum_add;
				phase_d = PH_LEN2;
			end
			PH_LEN2: begin
				len_d   = new_len;
				sum_d   = sum_add;
				count_d = '0;
				if (new_len > cfg.max_payload_len) begin
					has_result     = 1'b1;
					res.byte_index = new_len;
					res.frame_end  = 1'b1;
					res.status     = afd_pkg::ST_TOO_LONG;
					phase_d        = PH_HUNT;
				end else begin
					phase_d = (new_len == 16'd0) ? PH_CHECK : PH_DATA;
				end
			end
			PH_DATA: begin
				has_result       = 1'b1;
				res.payload_byte = in_byte;
				res.byte_index   = count_q;
				sum_d            = sum_add;
				count_d          = count_inc;
				if (count_inc >= len_q)
					phase_d = PH_CHECK;
			end
			PH_CHECK: begin
				has_result     = 1'b1;
				res.byte_index = len_q;
				res.frame_end  = 1'b1;
				res.status     = (sum_q == in_byte) ? afd_pkg::ST_GOOD : afd_pkg::ST_BAD_SUM;
				phase_d        = PH_HUNT;
			end
			default: begin
				if (in_byte == afd_pkg::PREAMBLE) begin
					sum_d   = afd_pkg::PREAMBLE;
					count_d = '0;
					phase_d = PH_TYPE;
				end else begin
					phase_d = PH_HUNT;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			kind_q  <= '0;
			len_q   <= '0;
			count_q <= '0;
			sum_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			kind_q  <= kind_d;
			len_q   <= len_d;
			count_q <= count_d;
			sum_q   <= sum_d;
		end
	end

	`AFD_ASSERT_IMP(a_data_in_range, clk, arst_n, phase_q == PH_DATA, count_q < len_q)
	`AFD_ASSERT_IMP(a_payload_only_in_data, clk, arst_n, has_result && !res.frame_end, phase_q == PH_DATA)
	`AFD_ASSERT_IMP(a_too_long_ends, clk, arst_n, has_result && res.status == afd_pkg::ST_TOO_LONG, res.frame_end)
	`AFD_ASSERT_NXT(a_check_to_hunt, clk, arst_n, step && phase_q == PH_CHECK, phase_q == PH_HUNT)

endmodule

/* hdl/api_frame_deframer.sv */
// Frame deframer top level: input register, parser, result register, config registers.
// Takes one byte per cycle while the input register does not stall; a byte is parsed in the
// cycle after the edge that accepts it, and any result it causes is loaded into the result
// register at the edge where that byte moves on. The input register stalls only while a
// result waits untaken and the byte in it would make another. Register writes are always
// accepted; after reset length_msb_first is 1 and max_payload_len is 255.
`include "api_frame_deframer_assert.svh"

module api_frame_deframer (
	input  logic         clk,
	input  logic         arst_n,
	afd_byte_if.sink     stream,
	afd_result_if.source result,
	afd_cfg_if.sink      cfg
);

	afd_pkg::afd_cfg_t    cfg_q;
	afd_pkg::afd_result_t res_d, res_q;
	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 has_result;
	logic                 advance;
	logic                 res_valid_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.length_msb_first <= afd_pkg::RST_LENGTH_MSB_FIRST;
			cfg_q.max_payload_len  <= afd_pkg::RST_MAX_PAYLOAD_LEN;
		end else if (cfg.valid) begin
			unique case (cfg.addr)
				afd_pkg::REG_LENGTH_MSB_FIRST: cfg_q.length_msb_first <= cfg.data[0];
				afd_pkg::REG_MAX_PAYLOAD_LEN:  cfg_q.max_payload_len  <= cfg.data[15:0];
			endcase
		end
	end

	// s1 moves on unless its result has nowhere to go
	assign advance      = valid_s1 && (!has_result || !res_valid_q || result.ready);
	assign stream.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.ready && stream.valid)
			byte_s1 <= stream.in_byte;
	end

	afd_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.in_byte    (byte_s1),
		.cfg        (cfg_q),
		.has_result (has_result),
		.res        (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && has_result) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result)
			res_q <= res_d;
	end

	assign result.valid        = res_valid_q;
	assign result.payload_byte = res_q.payload_byte;
	assign result.frame_kind   = res_q.frame_kind;
	assign result.byte_index   = res_q.byte_index;
	assign result.frame_end    = res_q.frame_end;
	assign result.status       = res_q.status;

	`AFD_ASSERT_NXT(a_s1_holds, clk, arst_n, valid_s1 && !advance, valid_s1 && $stable(byte_s1))
	`AFD_ASSERT_IMP(a_no_overwrite, clk, arst_n, res_valid_q && !result.ready, !(advance && has_result))
	`AFD_ASSERT_NXT(a_result_loaded, clk, arst_n, advance && has_result, res_valid_q)

endmodule

/* bench/tb.sv */
// Self-checking bench for the frame deframer: framed and broken byte streams against a parser model.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [2:0] {
		HUNT,
		TAKE_KIND,
		TAKE_LEN1,
		TAKE_LEN2,
		TAKE_DATA,
		TAKE_SUM
	} parse_phase_t;

	localparam int HOLD_CYCLES = 200;
	localparam int STALL_LIMIT = 1000;
	localparam int PHASE_BYTES = 380;

	logic clk = 1'b0;
	logic arst_n;

	afd_byte_if   stream_ch ();
	afd_result_if result_ch ();
	afd_cfg_if    cfg_ch ();

	api_frame_deframer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	always #5 clk = ~clk;

	// parser model state and register copies
	parse_phase_t m_phase     = HUNT;
	logic [7:0]   m_kind      = '0;
	logic [15:0]  m_len       = '0;
	logic [15:0]  m_count     = '0;
	logic [7:0]   m_sum       = '0;
	logic         m_msb_first = afd_pkg::RST_LENGTH_MSB_FIRST;
	logic [15:0]  m_max_len   = afd_pkg::RST_MAX_PAYLOAD_LEN;

	logic [7:0]           line_bytes[$];
	afd_pkg::afd_result_t deframed_q[$];
	int          err_count   = 0;
	int          bytes_taken = 0;
	int          pushed      = 0;

	int burst_left = 0;
	int gap_left   = 0;

	int  hold_left = 0;
	bit  hold_done = 1'b0;
	int  rx_mode   = 0;
	int  mode_left = 0;
	int  stall_cycles = 0;

	function automatic void deframe_byte(input logic [7:0] b);
		afd_pkg::afd_result_t r;
		logic [15:0] full_len;
		r = '0;
		r.frame_kind = m_kind;
		case (m_phase)
		TAKE_KIND: begin
			m_kind  = b;
			m_sum   = m_sum + b;
			m_phase = TAKE_LEN1;
		end
		TAKE_LEN1: begin
			m_len   = {8'h00, b};
			m_sum   = m_sum + b;
			m_phase = TAKE_LEN2;
		end
		TAKE_LEN2: begin
			full_len = m_msb_first ? {m_len[7:0], b} : {b, m_len[7:0]};
			m_len    = full_len;
			m_sum    = m_sum + b;
			m_count  = '0;
			if (full_len > m_max_len) begin
				r.byte_index = full_len;
				r.frame_end  = 1'b1;
				r.status     = afd_pkg::ST_TOO_LONG;
				deframed_q.push_back(r);
				m_phase = HUNT;
			end else if (full_len == 16'd0) begin
				m_phase = TAKE_SUM;
			end else begin
				m_phase = TAKE_DATA;
			end
		end
		TAKE_DATA: begin
			r.payload_byte = b;
			r.byte_index   = m_count;
			r.status       = afd_pkg::ST_GOOD;
			deframed_q.push_back(r);
			m_sum   = m_sum + b;
			m_count = m_count + 16'd1;
			if (m_count >= m_len)
				m_phase = TAKE_SUM;
		end
		TAKE_SUM: begin
			r.byte_index = m_len;
			r.frame_end  = 1'b1;
			r.status     = (m_sum == b) ? afd_pkg::ST_GOOD : afd_pkg::ST_BAD_SUM;
			deframed_q.push_back(r);
			m_phase = HUNT;
		end
		default: begin
			if (b == afd_pkg::PREAMBLE) begin
				m_sum   = afd_pkg::PREAMBLE;
				m_count = '0;
				m_phase = TAKE_KIND;
			end else begin
				m_phase = HUNT;
			end
		end
		endcase
	endfunction

	function automatic void check_field(input string what, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			err_count++;
			$display("%0t: %s expected %0d, got %0d", $time, what, want, got);
		end
	endfunction

	function automatic void put_byte(input logic [7:0] b);
		line_bytes.push_back(b);
		pushed++;
	endfunction

	// header in the current length order; payload and checksum only when within limit
	function automatic void send_frame(input logic [7:0] kind, input logic [15:0] len,
			input logic bad_sum);
		logic [7:0] sum;
		logic [7:0] first;
		logic [7:0] second;
		logic [7:0] b;
		first  = m_msb_first ? len[15:8] : len[7:0];
		second = m_msb_first ? len[7:0] : len[15:8];
		sum = afd_pkg::PREAMBLE + kind + first + second;
		put_byte(afd_pkg::PREAMBLE);
		put_byte(kind);
		put_byte(first);
		put_byte(second);
		if (len <= m_max_len) begin
			for (int i = 0; i < len; i++) begin
				b = 8'($urandom);
				sum = sum + b;
				put_byte(b);
			end
			b = bad_sum ? 8'(sum + 8'($urandom_range(1, 255))) : sum;
			put_byte(b);
		end
	endfunction

	function automatic void random_traffic(input int budget);
		int pick;
		int v;
		logic [15:0] len;
		pushed = 0;
		while (pushed < budget) begin
			pick = $urandom_range(0, 9);
			if (pick == 0 || (pick == 1 && m_max_len > 16'd300)) begin
				repeat ($urandom_range(1, 6)) begin
					v = $urandom_range(0, 255);
					put_byte(v == afd_pkg::PREAMBLE ? 8'hEC : 8'(v));
				end
			end else if (pick == 1) begin
				// truncated header, the next frame gets swallowed
				put_byte(afd_pkg::PREAMBLE);
				repeat ($urandom_range(0, 2))
					put_byte(8'($urandom));
			end else begin
				v = $urandom_range(0, 19);
				if (v < 15) begin
					len = 16'($urandom_range(0, 8));
				end else if (v < 17) begin
					v = int'(m_max_len) + int'($urandom_range(0, 2)) - 1;
					len = (v < 0) ? 16'd0 : ((v > 65535) ? 16'hFFFF : 16'(v));
				end else begin
					len = 16'($urandom);
				end
				if (len <= m_max_len && len > 16'd300)
					len = 16'($urandom_range(200, 300));
				send_frame(8'($urandom), len, $urandom_range(0, 4) == 0);
			end
		end
	endfunction

	task automatic drain();
		do
			@(posedge clk);
		while (line_bytes.size() != 0 || stream_ch.valid || deframed_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [afd_pkg::REG_ADDR_W-1:0] addr,
			input logic [15:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.addr  <= addr;
		cfg_ch.data  <= data;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_phase(input logic msb_first, input logic [15:0] max_len);
		write_reg(afd_pkg::REG_LENGTH_MSB_FIRST, {15'd0, msb_first});
		write_reg(afd_pkg::REG_MAX_PAYLOAD_LEN, max_len);
		random_traffic(PHASE_BYTES);
		drain();
	endtask

	// byte driver: bursts of random length, random gaps between them
	always @(posedge clk) begin
		if (!arst_n) begin
			stream_ch.valid <= 1'b0;
		end else if (!stream_ch.valid || stream_ch.ready) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				stream_ch.valid <= 1'b0;
			end else if (line_bytes.size() != 0) begin
				stream_ch.valid   <= 1'b1;
				stream_ch.in_byte <= line_bytes.pop_front();
				if (burst_left > 1) begin
					burst_left <= burst_left - 1;
				end else begin
					burst_left <= $urandom_range(1, 48);
					gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
				end
			end else begin
				stream_ch.valid <= 1'b0;
			end
		end
	end

	// result sink: changing stall pattern plus one long hold-off
	always @(posedge clk) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (!hold_done && bytes_taken >= 700) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					rx_mode   = $urandom_range(0, 2);
					mode_left = $urandom_range(16, 96);
				end else begin
					mode_left--;
				end
				case (rx_mode)
				0:       result_ch.ready <= 1'b1;
				1:       result_ch.ready <= 1'($urandom_range(0, 1));
				default: result_ch.ready <= (mode_left % 4 == 0);
				endcase
			end
		end
	end

	// observe every request on all three channels
	always @(posedge clk) begin
		afd_pkg::afd_result_t want;
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.addr)
				afd_pkg::REG_LENGTH_MSB_FIRST: m_msb_first = cfg_ch.data[0];
				afd_pkg::REG_MAX_PAYLOAD_LEN:  m_max_len   = cfg_ch.data;
				default: ;
				endcase
			end
			if (result_ch.valid && result_ch.ready) begin
				if (deframed_q.size() == 0) begin
					err_count++;
					$display("%0t: unexpected result, expected none, got byte %0d kind %0d %s",
						$time, result_ch.payload_byte, result_ch.frame_kind,
						$sformatf("index %0d end %0d status %0d", result_ch.byte_index,
						result_ch.frame_end, result_ch.status));
				end else begin
					want = deframed_q.pop_front();
					check_field("payload_byte", 16'(want.payload_byte),
						16'(result_ch.payload_byte));
					check_field("frame_kind", 16'(want.frame_kind), 16'(result_ch.frame_kind));
					check_field("byte_index", want.byte_index, result_ch.byte_index);
					check_field("frame_end", 16'(want.frame_end), 16'(result_ch.frame_end));
					check_field("status", 16'(want.status), 16'(result_ch.status));
				end
			end
			if (stream_ch.valid && stream_ch.ready) begin
				bytes_taken++;
				deframe_byte(stream_ch.in_byte);
			end
		end
	end

	always @(posedge clk) begin
		if ((stream_ch.valid && stream_ch.ready) || (result_ch.valid && result_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no request accepted for %0d cycles", $time, STALL_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		arst_n            = 1'b0;
		stream_ch.valid   = 1'b0;
		stream_ch.in_byte = '0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.addr       = '0;
		cfg_ch.data       = '0;
		result_ch.ready   = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// noise while hunting
		put_byte(8'h00);
		put_byte(8'hFF);
		put_byte(8'hEC);
		// zero length, good checksum
		put_byte(afd_pkg::PREAMBLE);
		put_byte(8'hFF);
		put_byte(8'h00);
		put_byte(8'h00);
		put_byte(8'hEC);
		// two payload bytes, checksum off by one
		put_byte(afd_pkg::PREAMBLE);
		put_byte(8'h00);
		put_byte(8'h00);
		put_byte(8'h02);
		put_byte(8'hFF);
		put_byte(8'h00);
		put_byte(8'hEF);
		// length 256 against the default limit
		put_byte(afd_pkg::PREAMBLE);
		put_byte(8'h5A);
		put_byte(8'h01);
		put_byte(8'h00);
		// payload equal to the preamble
		put_byte(afd_pkg::PREAMBLE);
		put_byte(8'h81);
		put_byte(8'h00);
		put_byte(8'h01);
		put_byte(afd_pkg::PREAMBLE);
		put_byte(8'h5C);
		drain();

		run_phase(1'b0, 16'd0);
		run_phase(1'b1, 16'hFFFF);
		run_phase(1'b0, 16'd20);
		run_phase(1'b1, 16'd255);

		repeat (8) @(posedge clk);
		if (deframed_q.size() != 0) begin
			err_count++;
			$display("%0t: %0d expected results never arrived", $time, deframed_q.size());
		end
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
